### rtl/core/cdn_pkg.sv
package cdn_pkg;

   // Value width for the signed calendar fields and the divider dividend
   localparam int VW = 48;
   // Divisor and remainder width of the constant divider
   localparam int DVW = 18;
   // Reciprocal width and scale (reciprocal = 2^RSH / divisor, rounded down)
   localparam int RW  = 31;
   localparam int RSH = 34;

   localparam logic [DVW-1:0] DIV_60   = DVW'(60);
   localparam logic [DVW-1:0] DIV_24   = DVW'(24);
   localparam logic [DVW-1:0] DIV_12   = DVW'(12);
   localparam logic [DVW-1:0] DIV_400  = DVW'(400);
   localparam logic [DVW-1:0] DIV_ERA  = DVW'(146097);
   localparam logic [DVW-1:0] DIV_1460 = DVW'(1460);
   localparam logic [DVW-1:0] DIV_365  = DVW'(365);
   localparam logic [DVW-1:0] DIV_153  = DVW'(153);
   localparam logic [DVW-1:0] DOE_LAST = DVW'(146096);

   localparam logic [RW-1:0] RCP_60   = RW'((64'd1 << RSH) / 64'd60);
   localparam logic [RW-1:0] RCP_24   = RW'((64'd1 << RSH) / 64'd24);
   localparam logic [RW-1:0] RCP_12   = RW'((64'd1 << RSH) / 64'd12);
   localparam logic [RW-1:0] RCP_400  = RW'((64'd1 << RSH) / 64'd400);
   localparam logic [RW-1:0] RCP_ERA  = RW'((64'd1 << RSH) / 64'd146097);
   localparam logic [RW-1:0] RCP_1460 = RW'((64'd1 << RSH) / 64'd1460);
   localparam logic [RW-1:0] RCP_365  = RW'((64'd1 << RSH) / 64'd365);
   localparam logic [RW-1:0] RCP_153  = RW'((64'd1 << RSH) / 64'd153);

   // Datapath operations, issued in this order
   typedef enum logic [4:0] {
      OP_SEC   = 5'd0,
      OP_MIN   = 5'd1,
      OP_HOUR  = 5'd2,
      OP_MON   = 5'd3,
      OP_ERA   = 5'd4,
      OP_PROD  = 5'd5,
      OP_ZZ    = 5'd6,
      OP_Q1460 = 5'd7,
      OP_Y365  = 5'd8,
      OP_MP    = 5'd9,
      OP_FIN   = 5'd10,
      OP_PK1   = 5'd11,
      OP_PK2   = 5'd12,
      OP_PK3   = 5'd13,
      OP_PK4   = 5'd14,
      OP_PK5   = 5'd15
   } op_type;

   typedef struct packed {
      logic   load;
      logic   start;
      logic   commit;
      logic   emit;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic rsp_busy;
   } sts_type;

   // Operations that need a pass through the divider
   function automatic logic op_divides(input op_type op);
      logic r;
      case (op)
         OP_SEC, OP_MIN, OP_HOUR, OP_MON, OP_ERA,
         OP_ZZ, OP_Q1460, OP_Y365, OP_MP: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic op_type op_next(input op_type op);
      op_type r;
      case (op)
         OP_SEC:   r = OP_MIN;
         OP_MIN:   r = OP_HOUR;
         OP_HOUR:  r = OP_MON;
         OP_MON:   r = OP_ERA;
         OP_ERA:   r = OP_PROD;
         OP_PROD:  r = OP_ZZ;
         OP_ZZ:    r = OP_Q1460;
         OP_Q1460: r = OP_Y365;
         OP_Y365:  r = OP_MP;
         OP_MP:    r = OP_FIN;
         OP_FIN:   r = OP_PK1;
         OP_PK1:   r = OP_PK2;
         OP_PK2:   r = OP_PK3;
         OP_PK3:   r = OP_PK4;
         OP_PK4:   r = OP_PK5;
         default:  r = OP_SEC;
      endcase
      return r;
   endfunction

   // Reciprocal that goes with each divisor
   function automatic logic [RW-1:0] recip_of(input logic [DVW-1:0] dv);
      logic [RW-1:0] r;
      case (dv)
         DIV_60:   r = RCP_60;
         DIV_24:   r = RCP_24;
         DIV_12:   r = RCP_12;
         DIV_400:  r = RCP_400;
         DIV_ERA:  r = RCP_ERA;
         DIV_1460: r = RCP_1460;
         DIV_365:  r = RCP_365;
         DIV_153:  r = RCP_153;
         default:  r = RCP_60;
      endcase
      return r;
   endfunction

   // Day of a March-based year at which shifted month mp starts
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] r;
      case (mp)
         4'd0:  r = 9'd0;
         4'd1:  r = 9'd31;
         4'd2:  r = 9'd61;
         4'd3:  r = 9'd92;
         4'd4:  r = 9'd122;
         4'd5:  r = 9'd153;
         4'd6:  r = 9'd184;
         4'd7:  r = 9'd214;
         4'd8:  r = 9'd245;
         4'd9:  r = 9'd275;
         4'd10: r = 9'd306;
         4'd11: r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // Days before year yoe of a 400-year cycle (yoe < 400)
   function automatic logic [17:0] days_before(input logic [8:0] yoe);
      logic [17:0] cent;
      cent = (yoe >= 9'd300) ? 18'd3 : (yoe >= 9'd200) ? 18'd2 :
             (yoe >= 9'd100) ? 18'd1 : 18'd0;
      return 18'(yoe) * 18'd365 + 18'(yoe[8:2]) - cent;
   endfunction

endpackage

### rtl/core/cdn_div.sv
// Constant floor divider: signed dividend, three 16-bit quotient digits,
// each a reciprocal estimate step followed by a one-step correction
module cdn_div
   import cdn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [VW-1:0]  dividend,
   input  logic [DVW-1:0]        divisor,
   output logic                  done,
   output logic signed [VW-1:0]  quotient,
   output logic [DVW-1:0]        remainder
);

   // Partial dividend: running remainder over one 16-bit digit
   localparam int TW = DVW + 16;
   localparam int PW = TW + RW;

   logic [1:0]     dig_ff, dig_in;
   logic           phase_ff, phase_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic           neg_ff, neg_in;
   logic [VW-1:0]  num_ff, num_in;
   logic [VW-1:0]  quo_ff, quo_in;
   logic [DVW-1:0] rem_ff, rem_in;
   logic [DVW-1:0] dvs_ff, dvs_in;
   logic [RW-1:0]  rcp_ff, rcp_in;
   logic [15:0]    est_ff, est_in;
   logic [TW-1:0]  part;
   logic [PW-1:0]  prod;
   logic [TW-1:0]  left;

   // Negative dividends run on the one's complement, then map back to floor
   assign part = {rem_ff, num_ff[VW-1:VW-16]};
   // Estimate is low by at most one, since part < 2^RSH
   assign prod = PW'(part) * PW'(rcp_ff);
   assign left = part - TW'(est_ff) * TW'(dvs_ff);

   always_comb begin
      dig_in   = dig_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      rcp_in   = rcp_ff;
      est_in   = est_ff;
      if (start) begin
         neg_in   = dividend[VW-1];
         num_in   = dividend[VW-1] ? ~dividend : dividend;
         quo_in   = '0;
         rem_in   = '0;
         dvs_in   = divisor;
         rcp_in   = recip_of(divisor);
         dig_in   = 2'd2;
         phase_in = 1'b0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            est_in   = prod[RSH+15:RSH];
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            num_in   = {num_ff[VW-17:0], 16'd0};
            if (left >= TW'(dvs_ff)) begin
               rem_in = DVW'(left - TW'(dvs_ff));
               quo_in = {quo_ff[VW-17:0], est_ff + 16'd1};
            end else begin
               rem_in = DVW'(left);
               quo_in = {quo_ff[VW-17:0], est_ff};
            end
            dig_in = dig_ff - 2'd1;
            if (dig_ff == 2'd0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dig_ff   <= '0;
         phase_ff <= 1'b0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         dig_ff   <= dig_in;
         phase_ff <= phase_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
      neg_ff <= neg_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      rcp_ff <= rcp_in;
      est_ff <= est_in;
   end

   assign done      = done_ff;
   assign quotient  = neg_ff ? $signed(~quo_ff) : $signed(quo_ff);
   assign remainder = neg_ff ? DVW'(dvs_ff - DVW'(1) - rem_ff) : rem_ff;

endmodule

### rtl/core/cdn_ctrl.sv
// Sequencer: walks the operation list, one divider pass per dividing step
module cdn_ctrl
   import cdn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SETUP  = 5'b00010,
      ST_RUN    = 5'b00100,
      ST_COMMIT = 5'b01000,
      ST_OUT    = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      cmd.load   = 1'b0;
      cmd.start  = 1'b0;
      cmd.commit = 1'b0;
      cmd.emit   = 1'b0;
      cmd.op     = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               op_in    = OP_SEC;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.start = 1'b1;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            if (sts.div_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            if (op_ff == OP_PK5) begin
               state_in = ST_OUT;
            end else begin
               op_in    = op_next(op_ff);
               state_in = op_divides(op_next(op_ff)) ? ST_SETUP : ST_COMMIT;
            end
         end
         ST_OUT: begin
            if (!sts.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_SEC;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

endmodule

### rtl/core/cdn_dp.sv
// Datapath: field registers, shared divider, day-serial math and packing
module cdn_dp
   import cdn_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   output sts_type       sts,
   input  logic [191:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [55:0]   rsp_tdata
);

   logic signed [VW-1:0] y_ff, y_in, mo_ff, mo_in, d_ff, d_in;
   logic signed [VW-1:0] h_ff, h_in, mi_ff, mi_in, s_ff, s_in;
   logic signed [VW-1:0] prod_ff, prod_in, acc_ff, acc_in;
   logic signed [23:0]   era_ff, era_in;
   logic [8:0]           yoe_ff, yoe_in, doy_ff, doy_in;
   logic [DVW-1:0]       doe_ff, doe_in, tmp_ff, tmp_in;
   logic                 bad_ff, bad_in;
   logic                 vld_ff, vld_in;
   logic [48:0]          out_ff, out_in;

   logic signed [VW-1:0] div_a;
   logic [DVW-1:0]       div_b;
   logic                 div_done;
   logic signed [VW-1:0] div_q;
   logic [DVW-1:0]       div_r;

   logic [3:0]           mp_sel;
   logic [3:0]           mp_q;
   logic [3:0]           nm;
   logic [DVW-1:0]       cent_q;
   logic signed [VW-1:0] fld;
   logic signed [VW-1:0] era400;

   cdn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // Dividend and divisor for each dividing step
   always_comb begin
      div_a = '0;
      div_b = DIV_60;
      case (cmd.op)
         OP_SEC:   begin div_a = s_ff;  div_b = DIV_60;  end
         OP_MIN:   begin div_a = mi_ff; div_b = DIV_60;  end
         OP_HOUR:  begin div_a = h_ff;  div_b = DIV_24;  end
         OP_MON:   begin div_a = mo_ff - VW'(1); div_b = DIV_12; end
         OP_ERA:   begin
            div_a = y_ff - ((mo_ff <= VW'(2)) ? VW'(1) : VW'(0));
            div_b = DIV_400;
         end
         OP_ZZ:    begin
            div_a = prod_ff + $signed(VW'(doe_ff)) + d_ff - VW'(1);
            div_b = DIV_ERA;
         end
         OP_Q1460: begin div_a = $signed(VW'(doe_ff)); div_b = DIV_1460; end
         OP_Y365:  begin div_a = $signed(VW'(tmp_ff)); div_b = DIV_365;  end
         OP_MP:    begin
            div_a = $signed(VW'(doy_ff) * VW'(5) + VW'(2));
            div_b = DIV_153;
         end
         default:  begin div_a = '0; div_b = DIV_60; end
      endcase
   end

   // Helpers for the commit arithmetic
   assign mp_sel = (mo_ff[3:0] >= 4'd3) ? mo_ff[3:0] - 4'd3 : mo_ff[3:0] + 4'd9;
   assign mp_q   = div_q[3:0];
   assign nm     = (mp_q < 4'd10) ? mp_q + 4'd3 : mp_q - 4'd9;
   assign cent_q = (doe_ff >= DVW'(146096)) ? DVW'(4) : (doe_ff >= DVW'(109572)) ? DVW'(3) :
                   (doe_ff >= DVW'(73048)) ? DVW'(2) : (doe_ff >= DVW'(36524)) ? DVW'(1) :
                   DVW'(0);
   assign era400 = VW'(era_ff) * VW'(400);

   always_comb begin
      case (cmd.op)
         OP_PK1:  fld = mo_ff;
         OP_PK2:  fld = d_ff;
         OP_PK3:  fld = h_ff;
         OP_PK4:  fld = mi_ff;
         default: fld = s_ff;
      endcase
   end

   // Register updates
   always_comb begin
      y_in = y_ff;  mo_in = mo_ff; d_in = d_ff;
      h_in = h_ff;  mi_in = mi_ff; s_in = s_ff;
      prod_in = prod_ff; acc_in = acc_ff; era_in = era_ff;
      yoe_in = yoe_ff; doy_in = doy_ff; doe_in = doe_ff; tmp_in = tmp_ff;
      bad_in = bad_ff;
      if (cmd.load) begin
         y_in  = VW'($signed(req_tdata[31:0]));
         mo_in = VW'($signed(req_tdata[63:32]));
         d_in  = VW'($signed(req_tdata[95:64]));
         h_in  = VW'($signed(req_tdata[127:96]));
         mi_in = VW'($signed(req_tdata[159:128]));
         s_in  = VW'($signed(req_tdata[191:160]));
      end else if (cmd.commit) begin
         case (cmd.op)
            OP_SEC:  begin s_in = VW'(div_r); mi_in = mi_ff + div_q; end
            OP_MIN:  begin mi_in = VW'(div_r); h_in = h_ff + div_q; end
            OP_HOUR: begin h_in = VW'(div_r); d_in = d_ff + div_q; end
            OP_MON:  begin mo_in = VW'(div_r) + VW'(1); y_in = y_ff + div_q; end
            OP_ERA:  begin
               era_in = div_q[23:0];
               doe_in = days_before(div_r[8:0]) + DVW'(month_start(mp_sel));
            end
            OP_PROD: prod_in = VW'(era_ff) * VW'(146097);
            OP_ZZ:   begin era_in = div_q[23:0]; doe_in = div_r; end
            OP_Q1460: tmp_in = doe_ff - div_q[DVW-1:0] + cent_q -
                               ((doe_ff == DOE_LAST) ? DVW'(1) : DVW'(0));
            OP_Y365: begin
               yoe_in = div_q[8:0];
               doy_in = 9'(doe_ff - days_before(div_q[8:0]));
            end
            OP_MP:   begin
               d_in  = VW'(doy_ff) - VW'(month_start(mp_q)) + VW'(1);
               mo_in = VW'(nm);
               y_in  = VW'(yoe_ff) + era400 + ((nm <= 4'd2) ? VW'(1) : VW'(0));
            end
            OP_FIN:  begin
               bad_in = (y_ff < VW'(1)) || (y_ff > VW'(9999));
               acc_in = y_ff;
            end
            default: acc_in = VW'(acc_ff * VW'(100)) + fld;
         endcase
      end
   end

   // Result register, free again once the beat is taken
   always_comb begin
      vld_in = vld_ff;
      out_in = out_ff;
      if (vld_ff && rsp_tready) begin
         vld_in = 1'b0;
      end
      if (cmd.emit) begin
         vld_in = 1'b1;
         out_in = bad_ff ? {1'b1, {VW{1'b1}}} : {1'b0, acc_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      y_ff <= y_in;   mo_ff <= mo_in; d_ff <= d_in;
      h_ff <= h_in;   mi_ff <= mi_in; s_ff <= s_in;
      prod_ff <= prod_in; acc_ff <= acc_in; era_ff <= era_in;
      yoe_ff <= yoe_in; doy_ff <= doy_in; doe_ff <= doe_in; tmp_ff <= tmp_in;
      bad_ff <= bad_in;
      out_ff <= out_in;
   end

   assign sts.div_done = div_done;
   assign sts.rsp_busy = vld_ff && !rsp_tready;
   assign rsp_tvalid   = vld_ff;
   assign rsp_tdata    = {7'd0, out_ff};

endmodule

### rtl/core/calendar_datetime_normalizer.sv
// Channel   Dir  Beat contents
// req_*     in   year, month, day, hour, minute, second (six signed 32-bit fields)
// rsp_*     out  packed_datetime (48-bit signed), out_of_range
//
// One item is worked at a time: 9 constant divisions (each a setup, three 16-bit
// quotient digits, done and commit), 7 more commit steps, the accept and the output
// step.
// Reset is synchronous; the block comes up idle with no result pending.
// A finished result waits in the output register; the next item is taken meanwhile,
// and its output step stalls until the waiting beat is taken.
module calendar_datetime_normalizer
   import cdn_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // year_in[31:0], month_in[63:32], day_in[95:64], hour_in[127:96],
   // minute_in[159:128], second_in[191:160]
   input  logic [191:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // packed_datetime[47:0], out_of_range[48], zero fill [55:49]
   output logic [55:0]  rsp_tdata
);

   cmd_type cmd;
   sts_type sts;

   cdn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   cdn_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef ASSERT_OFF
   // Out-of-range results carry all ones
   a_bad_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[48] |-> rsp_tdata[47:0] == {48{1'b1}})
      else $error("out_of_range result not all ones");

   // In-range results are never negative
   a_good_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[48] |-> !rsp_tdata[47])
      else $error("in-range result negative");

   // An accepted item keeps the block busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken again right after accept");
`endif

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import cdn_pkg::*;

   typedef struct packed {
      logic signed [31:0] second_v;
      logic signed [31:0] minute_v;
      logic signed [31:0] hour_v;
      logic signed [31:0] day_v;
      logic signed [31:0] month_v;
      logic signed [31:0] year_v;
   } stamp_t;

   typedef struct packed {
      logic        out_of_range;
      logic [47:0] packed_dt;
   } norm_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [55:0]  rsp_tdata;

   stamp_t pending_stamps[$];
   norm_t  expected_norms[$];
   int     error_count = 0;
   bit     stim_done = 1'b0;
   int     calm_beats = 0;

   calendar_datetime_normalizer dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #6 clock = ~clock;

   function automatic longint fdiv(longint a, longint b);
      longint q;
      q = a / b;
      if (a % b < 0) q = q - 1;
      return q;
   endfunction

   // Floor-style carries, month fold, then day serial round trip
   function automatic norm_t normalize(stamp_t st);
      longint y, mo, d, h, mi, s, c, yy, era, yoe, mp, doe, z, ny, nm, nd, doy;
      norm_t r;
      y = st.year_v; mo = st.month_v; d = st.day_v;
      h = st.hour_v; mi = st.minute_v; s = st.second_v;
      c = fdiv(s, 60); s -= c * 60; mi += c;
      c = fdiv(mi, 60); mi -= c * 60; h += c;
      c = fdiv(h, 24); h -= c * 24; d += c;
      c = fdiv(mo - 1, 12); mo = mo - c * 12; y += c;
      // serial of (y, mo, d), shifted to a March-based era origin
      yy = (mo <= 2) ? y - 1 : y;
      era = fdiv(yy, 400);
      yoe = yy - era * 400;
      mp = (mo + 9) % 12;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + (153 * mp + 2) / 5;
      z = era * 146097 + doe + d - 1;
      // back to civil
      era = fdiv(z, 146097);
      doe = z - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp = (5 * doy + 2) / 153;
      nm = (mp < 10) ? mp + 3 : mp - 9;
      nd = doy - (153 * mp + 2) / 5 + 1;
      ny = yoe + era * 400 + ((nm <= 2) ? 1 : 0);
      if (ny < 1 || ny > 9999) begin
         r.out_of_range = 1'b1;
         r.packed_dt = '1;
      end else begin
         r.out_of_range = 1'b0;
         r.packed_dt = 48'(ny * 64'd10000000000 + nm * 100000000 + nd * 1000000
                           + h * 10000 + mi * 100 + s);
      end
      return r;
   endfunction

   function automatic logic [31:0] rand_field(int near, int spread);
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'h8000_0000 + $urandom_range(0, 3);
         2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         3, 4: return 32'(near - spread * 3 + $urandom_range(0, spread * 6));
         default: return 32'(near + $urandom_range(0, spread - 1));
      endcase
   endfunction

   function automatic stamp_t mk(int y, int mo, int d, int h, int mi, int s);
      stamp_t st;
      st.year_v = y; st.month_v = mo; st.day_v = d;
      st.hour_v = h; st.minute_v = mi; st.second_v = s;
      return st;
   endfunction

   // Directed corners, then random stamps
   initial begin
      stamp_t st;
      int imin, imax;
      imin = 32'h8000_0000;
      imax = 32'h7FFF_FFFF;
      pending_stamps.push_back(mk(2024, 2, 29, 12, 30, 45));
      pending_stamps.push_back(mk(2023, 2, 29, 0, 0, 0));
      pending_stamps.push_back(mk(1900, 2, 29, 0, 0, 0));
      pending_stamps.push_back(mk(2000, 2, 29, 23, 59, 60));
      pending_stamps.push_back(mk(1, 1, 1, 0, 0, 0));
      pending_stamps.push_back(mk(1, 1, 1, 0, 0, -1));
      pending_stamps.push_back(mk(9999, 12, 31, 23, 59, 59));
      pending_stamps.push_back(mk(9999, 12, 31, 23, 59, 60));
      pending_stamps.push_back(mk(0, 2, 29, 0, 0, 0));
      pending_stamps.push_back(mk(2020, 0, 0, -1, -1, -1));
      pending_stamps.push_back(mk(2020, 13, 32, 24, 60, 60));
      pending_stamps.push_back(mk(2020, -25, -400, -48, -120, -7200));
      pending_stamps.push_back(mk(5000, imax, imax, imax, imax, imax));
      pending_stamps.push_back(mk(5000, imin, imin, imin, imin, imin));
      pending_stamps.push_back(mk(imax, imax, imax, imax, imax, imax));
      pending_stamps.push_back(mk(imin, imin, imin, imin, imin, imin));
      pending_stamps.push_back(mk(-1, -1, -1, -1, -1, -1));
      pending_stamps.push_back(mk(1970, 1, 1, 0, 0, imax));
      pending_stamps.push_back(mk(1970, 1, 1, 0, 0, imin));
      pending_stamps.push_back(mk(1, 1, 1, 0, imax, 0));
      pending_stamps.push_back(mk(9999, 12, imin, 0, 0, 0));
      pending_stamps.push_back(mk(2100, 3, -1, 0, 0, 0));
      for (int i = 0; i < 1800; i++) begin
         st.year_v   = rand_field(1 + $urandom_range(0, 9998), 1);
         st.month_v  = rand_field(1, 12);
         st.day_v    = rand_field(1, 31);
         st.hour_v   = rand_field(0, 24);
         st.minute_v = rand_field(0, 60);
         st.second_v = rand_field(0, 60);
         pending_stamps.push_back(st);
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Driver: one beat per handshake, idles now and then
   always @(posedge clock) begin
      stamp_t st;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_norms.push_back(normalize(stamp_t'(req_tdata)));
            calm_beats <= calm_beats + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_stamps.size() > 0 &&
                ((calm_beats > 300 && calm_beats < 700) || $urandom_range(0, 99) >= 10)) begin
               st = pending_stamps.pop_front();
               req_tdata <= st;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
               if (pending_stamps.size() == 0) stim_done <= 1'b1;
            end
         end
      end
   end

   // Monitor: compare each result beat with the oldest expectation
   always @(posedge clock) begin
      norm_t want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_norms.size() == 0) begin
               $error("unexpected result beat %h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_norms.pop_front();
               if (rsp_tdata[47:0] !== want.packed_dt) begin
                  $error("packed_datetime: expected %h, got %h", want.packed_dt,
                         rsp_tdata[47:0]);
                  error_count++;
               end
               if (rsp_tdata[48] !== want.out_of_range) begin
                  $error("out_of_range: expected %b, got %b", want.out_of_range,
                         rsp_tdata[48]);
                  error_count++;
               end
            end
         end
         rsp_tready <= (calm_beats > 300 && calm_beats < 700) || $urandom_range(0, 99) >= 10;
      end
   end

   // End of run
   initial begin
      wait (stim_done && !req_tvalid);
      wait (expected_norms.size() == 0);
      repeat (1000) @(posedge clock);
      if (error_count == 0 && expected_norms.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Watchdog
   initial begin
      #60_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

### files.f
rtl/core/cdn_pkg.sv
rtl/core/cdn_div.sv
rtl/core/cdn_ctrl.sv
rtl/core/cdn_dp.sv
rtl/core/calendar_datetime_normalizer.sv
tb/sv/testbench.sv
